// ===== design/sotc_pkg.sv =====
// Package for the scaled one-shot/loop timer with compare channels.
// Holds shared constants, register indexes, op codes and structs.
// No dependencies.
`default_nettype none

package sotc_pkg;

  localparam int NUM_COMPARE = 4;
  localparam int TIME_BITS   = 32;
  localparam int DELTA_BITS  = 24;
  localparam int SCALE_BITS  = 16;
  localparam int SCALE_FRAC  = 8;
  localparam int STEP_BITS   = DELTA_BITS + SCALE_BITS - SCALE_FRAC;
  localparam int PROG_FRAC   = 16;
  localparam int PROG_BITS   = PROG_FRAC + 1;
  localparam int REQ_BITS    = 3;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;
  localparam int REG_IDX_BITS = 3;

  localparam logic [TIME_BITS-1:0]  DURATION_RST = TIME_BITS'(65536);
  localparam logic [SCALE_BITS-1:0] SCALE_RST    = SCALE_BITS'(256);
  localparam logic [PROG_BITS-1:0]  PROG_ONE     = PROG_BITS'(1) << PROG_FRAC;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_DURATION       = 3'd0,
    REG_LOOP_ENABLE    = 3'd1,
    REG_TIME_SCALE     = 3'd2,
    REG_COMPARE_ENABLE = 3'd3,
    REG_COMPARE_TIME_0 = 3'd4,
    REG_COMPARE_TIME_1 = 3'd5,
    REG_COMPARE_TIME_2 = 3'd6,
    REG_COMPARE_TIME_3 = 3'd7
  } reg_idx_t;

  // Request codes as they arrive on the input
  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_RESET  = 3'd3,
    REQ_RESUME = 3'd4
  } req_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_RESET  = 3'd3,
    OP_RESUME = 3'd4,
    OP_NOP    = 3'd5
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [DELTA_BITS-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]                   duration;
    logic                                   loop_enable;
    logic [SCALE_BITS-1:0]                  time_scale;
    logic [NUM_COMPARE-1:0]                 compare_enable;
    logic [NUM_COMPARE-1:0][TIME_BITS-1:0]  compare_time;
  } cfg_t;

  typedef struct packed {
    logic                   active;
    logic                   finished;
    logic                   looped;
    logic [NUM_COMPARE-1:0] fired_mask;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   remaining;
    logic [PROG_BITS-1:0]   progress;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sotc_regs.sv =====
// Configuration register file with APB-style access.
// Depends on sotc_pkg.
`default_nettype none

module sotc_regs
  import sotc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [DATA_BITS-1:0]  cfg_pwdata,
  output logic      [DATA_BITS-1:0]  cfg_prdata,
  output logic                       cfg_pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_BITS-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duration       <= DURATION_RST;
      cfg_r.loop_enable    <= 1'b0;
      cfg_r.time_scale     <= SCALE_RST;
      cfg_r.compare_enable <= '0;
      cfg_r.compare_time   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DURATION:       cfg_r.duration       <= cfg_pwdata[TIME_BITS-1:0];
        REG_LOOP_ENABLE:    cfg_r.loop_enable    <= cfg_pwdata[0];
        REG_TIME_SCALE:     cfg_r.time_scale     <= cfg_pwdata[SCALE_BITS-1:0];
        REG_COMPARE_ENABLE: cfg_r.compare_enable <= cfg_pwdata[NUM_COMPARE-1:0];
        REG_COMPARE_TIME_0: cfg_r.compare_time[0] <= cfg_pwdata[TIME_BITS-1:0];
        REG_COMPARE_TIME_1: cfg_r.compare_time[1] <= cfg_pwdata[TIME_BITS-1:0];
        REG_COMPARE_TIME_2: cfg_r.compare_time[2] <= cfg_pwdata[TIME_BITS-1:0];
        REG_COMPARE_TIME_3: cfg_r.compare_time[3] <= cfg_pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_DURATION:       cfg_prdata = DATA_BITS'(cfg_r.duration);
      REG_LOOP_ENABLE:    cfg_prdata = DATA_BITS'(cfg_r.loop_enable);
      REG_TIME_SCALE:     cfg_prdata = DATA_BITS'(cfg_r.time_scale);
      REG_COMPARE_ENABLE: cfg_prdata = DATA_BITS'(cfg_r.compare_enable);
      REG_COMPARE_TIME_0: cfg_prdata = DATA_BITS'(cfg_r.compare_time[0]);
      REG_COMPARE_TIME_1: cfg_prdata = DATA_BITS'(cfg_r.compare_time[1]);
      REG_COMPARE_TIME_2: cfg_prdata = DATA_BITS'(cfg_r.compare_time[2]);
      REG_COMPARE_TIME_3: cfg_prdata = DATA_BITS'(cfg_r.compare_time[3]);
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sotc_front.sv =====
// Front end: accepts items, classifies the request code, and buffers
// commands in a two-entry queue for the back end. Depends on sotc_pkg.
`default_nettype none

module sotc_front
  import sotc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [REQ_BITS-1:0]    in_req_type,
  input  wire logic [DELTA_BITS-1:0]  in_delta_time,
  output logic                        q_valid,
  output cmd_t                        q_cmd,
  input  wire logic                   q_pop
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.delta = in_delta_time;
    unique case (in_req_type)
      REQ_TICK:   cmd_in.op = OP_TICK;
      REQ_START:  cmd_in.op = OP_START;
      REQ_STOP:   cmd_in.op = OP_STOP;
      REQ_RESET:  cmd_in.op = OP_RESET;
      REQ_RESUME: cmd_in.op = OP_RESUME;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign in_full = cnt_r[1];
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign push_ok = in_push & ~in_full;
  assign pop_ok  = q_pop & q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/sotc_exec.sv =====
// Back end: timer state, scaled tick step, compare channels, serial
// progress divider and the result register. Depends on sotc_pkg.
`default_nettype none

module sotc_exec
  import sotc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  output res_t       out_res,
  input  wire logic  out_take
);

  localparam int CNT_BITS = $clog2(PROG_FRAC);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PROG_FRAC - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_PREP = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t                  st_r, st_nxt;
  cmd_t                    cmd_r;
  logic [STEP_BITS-1:0]    step_r;
  logic [TIME_BITS-1:0]    sum_r;
  logic [TIME_BITS-1:0]    elapsed_r, elapsed_nxt;
  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic                    wrap_r, wrap_nxt;
  logic [NUM_COMPARE-1:0]  cf_r, cf_nxt;
  logic [NUM_COMPARE-1:0]  fired_r, fired_nxt;
  logic [TIME_BITS-1:0]    rem_r;
  logic [TIME_BITS-1:0]    div_r;
  logic [PROG_FRAC-1:0]    quo_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic [PROG_BITS-1:0]    prog_r;
  logic                    out_valid_r;
  res_t                    out_res_r;

  logic [DELTA_BITS+SCALE_BITS-1:0] prod;
  logic [TIME_BITS:0]               sum_wide;
  logic [TIME_BITS:0]               div_shift;
  logic                             div_ge;
  logic                             out_free;

  assign prod      = cfg.time_scale * cmd_r.delta;
  assign sum_wide  = {1'b0, elapsed_r} + (TIME_BITS+1)'(step_r);
  assign div_shift = {div_r, 1'b0};
  assign div_ge    = (div_shift >= {1'b0, cfg.duration});
  assign out_free  = ~out_valid_r | out_take;
  assign q_pop     = (st_r == ST_IDLE) & q_valid;

  // State update for the current command
  always_comb begin
    elapsed_nxt = elapsed_r;
    run_nxt     = run_r;
    done_nxt    = done_r;
    wrap_nxt    = wrap_r;
    cf_nxt      = cf_r;
    fired_nxt   = '0;
    unique case (cmd_r.op)
      OP_TICK: begin
        if (run_r) begin
          wrap_nxt    = 1'b0;
          elapsed_nxt = sum_r;
          for (int i = 0; i < NUM_COMPARE; i++) begin
            fired_nxt[i] = cfg.compare_enable[i] & ~cf_r[i] &
                           (sum_r >= cfg.compare_time[i]);
          end
          cf_nxt = cf_r | fired_nxt;
          if (sum_r >= cfg.duration) begin
            if (cfg.loop_enable) begin
              elapsed_nxt = '0;
              done_nxt    = 1'b0;
              wrap_nxt    = 1'b1;
              cf_nxt      = '0;
            end else begin
              done_nxt = 1'b1;
              run_nxt  = 1'b0;
            end
          end
        end
      end
      OP_START: begin
        elapsed_nxt = '0;
        run_nxt     = 1'b1;
        done_nxt    = 1'b0;
        wrap_nxt    = 1'b0;
        cf_nxt      = '0;
      end
      OP_STOP: begin
        run_nxt = 1'b0;
      end
      OP_RESET: begin
        elapsed_nxt = '0;
        run_nxt     = 1'b0;
        done_nxt    = 1'b0;
        wrap_nxt    = 1'b0;
        cf_nxt      = '0;
      end
      OP_RESUME: begin
        if (elapsed_r < cfg.duration) begin
          run_nxt  = 1'b1;
          done_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_ADD;
      ST_ADD:  st_nxt = ST_CMP;
      ST_CMP:  st_nxt = ST_PREP;
      ST_PREP: begin
        if ((cfg.duration == '0) || (elapsed_r >= cfg.duration)) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV:  if (cnt_r == CNT_LAST) st_nxt = ST_OUT;
      ST_OUT:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      elapsed_r   <= '0;
      run_r       <= 1'b0;
      done_r      <= 1'b0;
      wrap_r      <= 1'b0;
      cf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CMP) begin
        elapsed_r <= elapsed_nxt;
        run_r     <= run_nxt;
        done_r    <= done_nxt;
        wrap_r    <= wrap_nxt;
        cf_r      <= cf_nxt;
      end
      if ((st_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: cmd_r <= q_cmd;
      ST_MUL:  step_r <= prod[DELTA_BITS+SCALE_BITS-1:SCALE_FRAC];
      ST_ADD: begin
        // saturate at the top of the time range
        sum_r <= sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
      end
      ST_CMP:  fired_r <= fired_nxt;
      ST_PREP: begin
        rem_r  <= (cfg.duration > elapsed_r) ? (cfg.duration - elapsed_r) : '0;
        prog_r <= PROG_ONE;
        div_r  <= elapsed_r;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      ST_DIV: begin
        // one quotient bit per cycle, restoring
        if (div_ge) begin
          div_r <= TIME_BITS'(div_shift - {1'b0, cfg.duration});
        end else begin
          div_r <= div_shift[TIME_BITS-1:0];
        end
        quo_r  <= {quo_r[PROG_FRAC-2:0], div_ge};
        prog_r <= {1'b0, quo_r[PROG_FRAC-2:0], div_ge};
        cnt_r  <= cnt_r + CNT_BITS'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          out_res_r.active     <= run_r;
          out_res_r.finished   <= done_r;
          out_res_r.looped     <= wrap_r;
          out_res_r.fired_mask <= fired_r;
          out_res_r.elapsed    <= elapsed_r;
          out_res_r.remaining  <= rem_r;
          out_res_r.progress   <= prog_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ===== design/scaled_oneshot_loop_timer_compare.sv =====
// Top level of the scaled one-shot/loop timer with compare channels.
// Instantiates sotc_regs, sotc_front and sotc_exec; uses sotc_pkg.
//
// Items (ticks and commands) enter through a two-entry queue and are
// executed one at a time; each item yields exactly one result, held in an
// output register until popped. An item leaves the queue and passes through
// the multiply, add, compare and prep states, then the bit-serial divider
// computing progress = elapsed/duration in Q1.16, then the output state.
// The division is skipped when elapsed time has reached the duration or
// the duration is zero. Write configuration only while no item is in
// flight.
`default_nettype none

module scaled_oneshot_loop_timer_compare
  import sotc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [REQ_BITS-1:0]    in_req_type,
  input  wire logic [DELTA_BITS-1:0]  in_delta_time,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic                        out_active,
  output logic                        out_finished,
  output logic                        out_looped,
  output logic [NUM_COMPARE-1:0]      out_fired_mask,
  output logic [TIME_BITS-1:0]        out_elapsed,
  output logic [TIME_BITS-1:0]        out_remaining,
  output logic [PROG_BITS-1:0]        out_progress,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [ADDR_BITS-1:0]   cfg_paddr,
  input  wire logic [DATA_BITS-1:0]   cfg_pwdata,
  output logic      [DATA_BITS-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  logic out_valid;
  res_t out_res;

  sotc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sotc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_delta_time (in_delta_time),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  sotc_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_take  (out_pop & out_valid)
  );

  assign out_empty      = ~out_valid;
  assign out_active     = out_res.active;
  assign out_finished   = out_res.finished;
  assign out_looped     = out_res.looped;
  assign out_fired_mask = out_res.fired_mask;
  assign out_elapsed    = out_res.elapsed;
  assign out_remaining  = out_res.remaining;
  assign out_progress   = out_res.progress;

endmodule

`default_nettype wire
